// File: src/cmm_pkg.sv
// Shared widths, constants and controller-to-datapath command types.
package cmm_pkg;

  // Widths of the beat fields.
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned COMP_W = 32;
  localparam int unsigned OUT_W  = 48;

  // Fixed-point layout and internal widths.
  localparam int unsigned FRAC_W     = 30;
  localparam int unsigned PROD_W     = 2 * COMP_W;
  localparam int unsigned TERM_W     = PROD_W + 1;
  localparam int unsigned ACC_W      = 68;
  localparam int unsigned ADDR_MAX_W = 6;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic                  load;
    logic                  issue;
    logic [ADDR_MAX_W-1:0] addr_a;
    logic [ADDR_MAX_W-1:0] addr_b;
    logic                  first_k;
    logic                  last_k;
    logic                  fin;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;
  } stat_t;

endpackage

// File: src/cmm_if.sv
// Stream interfaces for load beats and product beats.
interface cmm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [cmm_pkg::IDX_W-1:0]        row;
  logic [cmm_pkg::IDX_W-1:0]        col;
  logic signed [cmm_pkg::COMP_W-1:0] in_re;
  logic signed [cmm_pkg::COMP_W-1:0] in_im;
  logic                             start_req;

  modport source (output valid, kind, row, col, in_re, in_im, start_req, input ready);
  modport sink   (input valid, kind, row, col, in_re, in_im, start_req, output ready);
endinterface

interface cmm_out_if;
  logic                             valid;
  logic                             ready;
  logic [cmm_pkg::IDX_W-1:0]        out_row;
  logic [cmm_pkg::IDX_W-1:0]        out_col;
  logic signed [cmm_pkg::OUT_W-1:0] out_re;
  logic signed [cmm_pkg::OUT_W-1:0] out_im;
  logic                             final_res;

  modport source (output valid, out_row, out_col, out_re, out_im, final_res, input ready);
  modport sink   (input valid, out_row, out_col, out_re, out_im, final_res, output ready);
endinterface

// File: src/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 9,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cmm_ctrl.sv
// Controller: accepts loads and sequences the row, column and inner-index loops.
module cmm_ctrl #(
  parameter int unsigned DIM = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_start_i,
  output logic           in_ready_o,
  input  cmm_pkg::stat_t stat_i,
  output cmm_pkg::cmd_t  cmd_o
);

  localparam int unsigned IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned AW = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam logic [AW-1:0] DIM_A  = AW'(DIM);
  localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e        state_q;
  logic [IW-1:0] r_q, c_q, k_q;
  logic          r_last, c_last, k_last;
  logic [AW-1:0] addr_a, addr_b;

  assign r_last = (r_q == LAST_I);
  assign c_last = (c_q == LAST_I);
  assign k_last = (k_q == LAST_I);
  assign addr_a = AW'(r_q) * DIM_A + AW'(k_q);
  assign addr_b = AW'(k_q) * DIM_A + AW'(c_q);

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.issue   = (state_q == ST_RUN);
    cmd_o.addr_a  = cmm_pkg::ADDR_MAX_W'(addr_a);
    cmd_o.addr_b  = cmm_pkg::ADDR_MAX_W'(addr_b);
    cmd_o.first_k = (k_q == '0);
    cmd_o.last_k  = k_last;
    cmd_o.fin     = r_last && c_last;
    cmd_o.row     = cmm_pkg::IDX_W'(r_q);
    cmd_o.col     = cmm_pkg::IDX_W'(c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_start_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (stat_i.adv) begin
            if (k_last) begin
              k_q <= '0;
              if (c_last) begin
                c_q <= '0;
                if (r_last) begin
                  r_q     <= '0;
                  state_q <= ST_IDLE;
                end else begin
                  r_q <= r_q + IW'(1);
                end
              end else begin
                c_q <= c_q + IW'(1);
              end
            end else begin
              k_q <= k_q + IW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/cmm_datapath.sv
// Datapath: element stores, complex multiply-accumulate pipeline and output register.
module cmm_datapath #(
  parameter int unsigned DIM = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmm_pkg::cmd_t                     cmd_i,
  output cmm_pkg::stat_t                    stat_o,
  input  logic                              in_kind_i,
  input  logic [cmm_pkg::IDX_W-1:0]         in_row_i,
  input  logic [cmm_pkg::IDX_W-1:0]         in_col_i,
  input  logic signed [cmm_pkg::COMP_W-1:0] in_re_i,
  input  logic signed [cmm_pkg::COMP_W-1:0] in_im_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cmm_pkg::IDX_W-1:0]         out_row_o,
  output logic [cmm_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [cmm_pkg::OUT_W-1:0]  out_re_o,
  output logic signed [cmm_pkg::OUT_W-1:0]  out_im_o,
  output logic                              out_final_o
);

  localparam int unsigned AW    = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int unsigned CW    = cmm_pkg::COMP_W;
  localparam int unsigned EW    = 2 * CW;
  localparam int unsigned PW    = cmm_pkg::PROD_W;
  localparam int unsigned TW    = cmm_pkg::TERM_W;
  localparam int unsigned ACW   = cmm_pkg::ACC_W;
  localparam int unsigned OW    = cmm_pkg::OUT_W;
  localparam int unsigned FW    = cmm_pkg::FRAC_W;
  localparam logic [AW-1:0] DIM_A = AW'(DIM);
  localparam logic [cmm_pkg::IDX_W:0] DIM_L = (cmm_pkg::IDX_W + 1)'(DIM);
  localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'(1) << (FW - 1);

  typedef struct packed {
    logic                      first_k;
    logic                      last_k;
    logic                      fin;
    logic [cmm_pkg::IDX_W-1:0] row;
    logic [cmm_pkg::IDX_W-1:0] col;
  } tag_t;

  // Store writes.
  logic          in_range;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          we_a, we_b;
  logic [EW-1:0] rdata_a, rdata_b;
  logic          adv;

  assign in_range = ({1'b0, in_row_i} < DIM_L) && ({1'b0, in_col_i} < DIM_L);
  assign waddr    = AW'(in_row_i) * DIM_A + AW'(in_col_i);
  assign wdata    = {in_re_i, in_im_i};
  assign we_a     = cmd_i.load && in_range && !in_kind_i;
  assign we_b     = cmd_i.load && in_range && in_kind_i;

  // The whole pipeline holds while a finished result waits at the output.
  assign adv        = !out_valid_o || out_ready_i;
  assign stat_o.adv = adv;

  cmm_ram #(.WIDTH(EW), .DEPTH(DIM * DIM)) u_left (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (cmd_i.addr_a[AW-1:0]),
    .rdata_o (rdata_a)
  );

  cmm_ram #(.WIDTH(EW), .DEPTH(DIM * DIM)) u_right (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (cmd_i.addr_b[AW-1:0]),
    .rdata_o (rdata_b)
  );

  // Stage 1: read data from both stores.
  logic v1_q;
  tag_t tag1_q;
  logic signed [CW-1:0] a_re, a_im, b_re, b_im;

  assign a_re = $signed(rdata_a[EW-1:CW]);
  assign a_im = $signed(rdata_a[CW-1:0]);
  assign b_re = $signed(rdata_b[EW-1:CW]);
  assign b_im = $signed(rdata_b[CW-1:0]);

  // Stage 2: four partial products.
  logic v2_q;
  tag_t tag2_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  // Stage 3: complex product term.
  logic v3_q;
  tag_t tag3_q;
  logic signed [TW-1:0] t_re_q, t_im_q;

  // Stage 4: accumulation and rounding.
  logic signed [ACW-1:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic signed [ACW-1:0] sh_re, sh_im;

  assign acc_re_d = (tag3_q.first_k ? ROUND_BIAS : acc_re_q) + ACW'(t_re_q);
  assign acc_im_d = (tag3_q.first_k ? ROUND_BIAS : acc_im_q) + ACW'(t_im_q);
  assign sh_re    = acc_re_d >>> FW;
  assign sh_im    = acc_im_d >>> FW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= cmd_i.issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      if (adv && v3_q && tag3_q.last_k) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q.first_k <= cmd_i.first_k;
      tag1_q.last_k  <= cmd_i.last_k;
      tag1_q.fin     <= cmd_i.fin;
      tag1_q.row     <= cmd_i.row;
      tag1_q.col     <= cmd_i.col;
      tag2_q         <= tag1_q;
      tag3_q         <= tag2_q;
      p_rr_q         <= a_re * b_re;
      p_ii_q         <= a_im * b_im;
      p_ri_q         <= a_re * b_im;
      p_ir_q         <= a_im * b_re;
      t_re_q         <= TW'(p_rr_q) - TW'(p_ii_q);
      t_im_q         <= TW'(p_ri_q) + TW'(p_ir_q);
      if (v3_q) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
        if (tag3_q.last_k) begin
          out_row_o   <= tag3_q.row;
          out_col_o   <= tag3_q.col;
          out_re_o    <= sh_re[OW-1:0];
          out_im_o    <= sh_im[OW-1:0];
          out_final_o <= tag3_q.fin;
        end
      end
    end
  end

endmodule

// File: src/complex_matrix_multiply.sv
// Top level of the complex matrix multiplier: controller, datapath and stream ports.
//
//   Channel  Dir  Modport            Beat contents
//   -------  ---  -----------------  ------------------------------------------
//   in_i     in   cmm_in_if.sink     kind, row, col, in_re, in_im, start_req
//   out_o    out  cmm_out_if.source  out_row, out_col, out_re, out_im, final_res
//
// A load beat with its row and column in range is written into the left or
// right store. A beat with start_req set is loaded, then the block issues one
// complex multiply-accumulate per cycle while out_o is not stalled, bounded by
// the single four-multiplier MAC and the one read port of each store. Each
// result goes through the store read, product and term registers to the output.
// Reset clears only control state; the stores need no clearing pass.
// A result that waits on out_o freezes the whole MAC pipeline until it is taken;
// in_i is not ready while a product is being issued.
module complex_matrix_multiply #(
  parameter int unsigned DIM = 3
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cmm_in_if.sink  in_i,
  cmm_out_if.source out_o
);

  cmm_pkg::cmd_t  cmd;
  cmm_pkg::stat_t stat;

  // The controller owns the input handshake and the loop counters.
  cmm_ctrl #(.DIM(DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_start_i (in_i.start_req),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds both stores, the MAC pipeline and the output register.
  cmm_datapath #(.DIM(DIM)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_kind_i   (in_i.kind),
    .in_row_i    (in_i.row),
    .in_col_i    (in_i.col),
    .in_re_i     (in_i.in_re),
    .in_im_i     (in_i.in_im),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_re_o    (out_o.out_re),
    .out_im_o    (out_o.out_im),
    .out_final_o (out_o.final_res)
  );

endmodule

// File: src/cmm_checker.sv
// Port-level checker for the complex matrix multiplier and its bind.
module cmm_checker #(
  parameter int unsigned DIM = 3
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_start_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [cmm_pkg::IDX_W-1:0]         out_row_i,
  input logic [cmm_pkg::IDX_W-1:0]         out_col_i,
  input logic signed [cmm_pkg::OUT_W-1:0]  out_re_i,
  input logic signed [cmm_pkg::OUT_W-1:0]  out_im_i,
  input logic                              out_final_i
);

  localparam logic [cmm_pkg::IDX_W-1:0] LAST_I = cmm_pkg::IDX_W'(DIM - 1);

  // The final flag marks exactly the bottom-right element.
  a_final_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_final_i == ((out_row_i == LAST_I) && (out_col_i == LAST_I))))
    else $error("final_res does not match the last element position");

  // A start beat closes the load port for the following cycle.
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_start_i) |=> !in_ready_i)
    else $error("load port ready right after a start beat");

  // Results stay well inside 48 bits, so the top bits are pure sign.
  a_headroom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (((out_re_i[47:37] == '0) || (out_re_i[47:37] == '1)) &&
                     ((out_im_i[47:37] == '0) || (out_im_i[47:37] == '1))))
    else $error("product element exceeds expected range");

  // A stalled result beat holds its contents.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_row_i) && $stable(out_col_i) &&
       $stable(out_re_i) && $stable(out_im_i) && $stable(out_final_i)))
    else $error("stalled result beat changed");

endmodule

bind complex_matrix_multiply cmm_checker #(.DIM(DIM)) u_cmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_start_i  (in_i.start_req),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.out_row),
  .out_col_i   (out_o.out_col),
  .out_re_i    (out_o.out_re),
  .out_im_i    (out_o.out_im),
  .out_final_i (out_o.final_res)
);
